/* hdl/aabb_pair_merge_overlap_macros.svh */
// -----------------------------------------------------------------------------
// aabb pair merge overlap assertion macros
// shared property forms for the checker, clocked on clock, reset active high
// -----------------------------------------------------------------------------
`ifndef AABB_PAIR_MERGE_OVERLAP_MACROS_SVH
`define AABB_PAIR_MERGE_OVERLAP_MACROS_SVH

// antecedent and consequent in the same cycle, off during reset
`define APMO_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("apmo property violated");

// consequent in the cycle after the antecedent, off during reset
`define APMO_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("apmo property violated");

// consequent in the cycle after the antecedent, also checked across reset
`define APMO_ASSERT_RESET(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("apmo reset property violated");

`endif

/* hdl/apmo_pkg.sv */
// -----------------------------------------------------------------------------
// apmo_pkg
// shared constants and pipeline control type of the box pair merge block
// -----------------------------------------------------------------------------
package apmo_pkg;

   // coordinate width in bits, centers signed, half sizes one bit narrower
   localparam int COORD_WIDTH_DEFAULT = 16;

   // register stages from input transaction to output register
   localparam int STAGES = 4;

   // pipeline stage indexes
   localparam int STAGE_RANGE  = 0;
   localparam int STAGE_BOUNDS = 1;
   localparam int STAGE_MERGE  = 2;
   localparam int STAGE_OUTPUT = 3;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

/* hdl/apmo_if.sv */
// -----------------------------------------------------------------------------
// apmo request and response channels
// valid/ready channels carrying one box pair and one merge result
// -----------------------------------------------------------------------------
interface apmo_req_if #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_center_x;
   logic signed [COORD_WIDTH-1:0] first_center_y;
   logic signed [COORD_WIDTH-1:0] first_center_z;
   logic        [COORD_WIDTH-2:0] first_half_x;
   logic        [COORD_WIDTH-2:0] first_half_y;
   logic        [COORD_WIDTH-2:0] first_half_z;
   logic signed [COORD_WIDTH-1:0] second_center_x;
   logic signed [COORD_WIDTH-1:0] second_center_y;
   logic signed [COORD_WIDTH-1:0] second_center_z;
   logic        [COORD_WIDTH-2:0] second_half_x;
   logic        [COORD_WIDTH-2:0] second_half_y;
   logic        [COORD_WIDTH-2:0] second_half_z;

   modport source (
      output valid, first_center_x, first_center_y, first_center_z,
             first_half_x, first_half_y, first_half_z,
             second_center_x, second_center_y, second_center_z,
             second_half_x, second_half_y, second_half_z,
      input  ready
   );

   modport sink (
      input  valid, first_center_x, first_center_y, first_center_z,
             first_half_x, first_half_y, first_half_z,
             second_center_x, second_center_y, second_center_z,
             second_half_x, second_half_y, second_half_z,
      output ready
   );
endinterface

interface apmo_rsp_if #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH:0]   merged_center_x;
   logic signed [COORD_WIDTH:0]   merged_center_y;
   logic signed [COORD_WIDTH:0]   merged_center_z;
   logic        [COORD_WIDTH-1:0] merged_half_x;
   logic        [COORD_WIDTH-1:0] merged_half_y;
   logic        [COORD_WIDTH-1:0] merged_half_z;
   logic        [3*COORD_WIDTH-1:0] overlap_volume;
   logic                          contained;

   modport source (
      output valid, merged_center_x, merged_center_y, merged_center_z,
             merged_half_x, merged_half_y, merged_half_z,
             overlap_volume, contained,
      input  ready
   );

   modport sink (
      input  valid, merged_center_x, merged_center_y, merged_center_z,
             merged_half_x, merged_half_y, merged_half_z,
             overlap_volume, contained,
      output ready
   );
endinterface

/* hdl/apmo_ctrl.sv */
// -----------------------------------------------------------------------------
// apmo_ctrl
// valid bits and per-stage load enables of the four-stage pipeline
// -----------------------------------------------------------------------------
module apmo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output apmo_pkg::pipe_ctrl_type pipe
);

   logic [apmo_pkg::STAGES-1:0] valid_ff;
   logic [apmo_pkg::STAGES-1:0] valid_in;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      pipe.load[apmo_pkg::STAGES-1] = !valid_ff[apmo_pkg::STAGES-1] || out_ready;
      for (int k = apmo_pkg::STAGES - 2; k >= 0; k--) begin
         pipe.load[k] = !valid_ff[k] || pipe.load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = pipe.load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < apmo_pkg::STAGES; k++) begin
         valid_in[k] = pipe.load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = pipe.load[0];
   assign out_valid = valid_ff[apmo_pkg::STAGES-1];

endmodule

/* hdl/apmo_axis.sv */
// -----------------------------------------------------------------------------
// apmo_axis
// one axis: box bounds, merged center and half size, overlap and containment
// -----------------------------------------------------------------------------
module apmo_axis #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  apmo_pkg::pipe_ctrl_type       pipe,
   input  logic signed [COORD_WIDTH-1:0] center_a,
   input  logic        [COORD_WIDTH-2:0] half_a,
   input  logic signed [COORD_WIDTH-1:0] center_b,
   input  logic        [COORD_WIDTH-2:0] half_b,
   output logic signed [COORD_WIDTH:0]   merged_center,
   output logic        [COORD_WIDTH-1:0] merged_half,
   output logic        [COORD_WIDTH-1:0] overlap,
   output logic                          contained
);

   localparam int C = COORD_WIDTH;

   // stage 1: box bounds and center distance
   logic signed [C:0]   lo_a_in, hi_a_in, lo_b_in, hi_b_in, diff;
   logic signed [C:0]   lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff;
   logic        [C-1:0] dist_in, dist_ff;
   logic        [C-2:0] half_a_ff, half_b_ff;

   // stage 2: enclosing bounds, clamped overlap, containment
   logic signed [C:0]   lo_in, hi_in, lo_ff, hi_ff;
   logic        [C-1:0] hsum;
   logic signed [C+1:0] ov_raw;
   logic        [C-1:0] overlap_in, overlap_ff;
   logic        [C:0]   reach;
   logic                inside_in, inside_ff;

   // stage 3: merged center and half size
   logic signed [C+1:0] sum, span;
   logic signed [C:0]   merged_center_ff;
   logic        [C-1:0] merged_half_ff;

   always_comb begin
      lo_a_in = $signed({center_a[C-1], center_a}) - $signed({2'b00, half_a});
      hi_a_in = $signed({center_a[C-1], center_a}) + $signed({2'b00, half_a});
      lo_b_in = $signed({center_b[C-1], center_b}) - $signed({2'b00, half_b});
      hi_b_in = $signed({center_b[C-1], center_b}) + $signed({2'b00, half_b});
      diff    = $signed({center_a[C-1], center_a}) - $signed({center_b[C-1], center_b});
      dist_in = diff[C] ? C'(-diff) : diff[C-1:0];
   end

   always_ff @(posedge clock) begin
      if (pipe.load[apmo_pkg::STAGE_RANGE]) begin
         lo_a_ff   <= lo_a_in;
         hi_a_ff   <= hi_a_in;
         lo_b_ff   <= lo_b_in;
         hi_b_ff   <= hi_b_in;
         dist_ff   <= dist_in;
         half_a_ff <= half_a;
         half_b_ff <= half_b;
      end
   end

   always_comb begin
      lo_in      = (lo_a_ff < lo_b_ff) ? lo_a_ff : lo_b_ff;
      hi_in      = (hi_a_ff > hi_b_ff) ? hi_a_ff : hi_b_ff;
      hsum       = {1'b0, half_a_ff} + {1'b0, half_b_ff};
      ov_raw     = $signed({2'b00, hsum}) - $signed({2'b00, dist_ff});
      overlap_in = ov_raw[C+1] ? '0 : ov_raw[C-1:0];
      reach      = {1'b0, dist_ff} + {2'b00, half_b_ff};
      inside_in  = reach <= {2'b00, half_a_ff};
   end

   always_ff @(posedge clock) begin
      if (pipe.load[apmo_pkg::STAGE_BOUNDS]) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         overlap_ff <= overlap_in;
         inside_ff  <= inside_in;
      end
   end

   // floor halving is the arithmetic shift, span is never negative
   always_comb begin
      sum  = $signed({lo_ff[C], lo_ff}) + $signed({hi_ff[C], hi_ff});
      span = $signed({hi_ff[C], hi_ff}) - $signed({lo_ff[C], lo_ff});
   end

   always_ff @(posedge clock) begin
      if (pipe.load[apmo_pkg::STAGE_MERGE]) begin
         merged_center_ff <= sum[C+1:1];
         merged_half_ff   <= span[C:1];
      end
   end

   assign merged_center = merged_center_ff;
   assign merged_half   = merged_half_ff;
   assign overlap       = overlap_ff;
   assign contained     = inside_ff;

endmodule

/* hdl/apmo_volume.sv */
// -----------------------------------------------------------------------------
// apmo_volume
// overlap volume as two registered multiplies, x by y, then by z
// -----------------------------------------------------------------------------
module apmo_volume #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  apmo_pkg::pipe_ctrl_type      pipe,
   input  logic [COORD_WIDTH-1:0]       overlap_x,
   input  logic [COORD_WIDTH-1:0]       overlap_y,
   input  logic [COORD_WIDTH-1:0]       overlap_z,
   output logic [3*COORD_WIDTH-1:0]     volume
);

   localparam int C = COORD_WIDTH;

   logic [2*C-1:0] area_in, area_ff;
   logic [C-1:0]   overlap_z_ff;
   logic [3*C-1:0] volume_in, volume_ff;

   assign area_in   = (2*C)'(overlap_x) * (2*C)'(overlap_y);
   assign volume_in = (3*C)'(area_ff) * (3*C)'(overlap_z_ff);

   always_ff @(posedge clock) begin
      if (pipe.load[apmo_pkg::STAGE_MERGE]) begin
         area_ff      <= area_in;
         overlap_z_ff <= overlap_z;
      end
      if (pipe.load[apmo_pkg::STAGE_OUTPUT]) begin
         volume_ff <= volume_in;
      end
   end

   assign volume = volume_ff;

endmodule

/* hdl/aabb_pair_merge_overlap.sv */
// -----------------------------------------------------------------------------
// aabb_pair_merge_overlap
// merged enclosing box, overlap volume and containment of two 3d boxes
// -----------------------------------------------------------------------------
// four register stages from input to result valid: range, bounds, merge, output
// throughput: one box pair per cycle unless the output stalls, set by the stages
//    and the two multiplies of the volume path, each closed by its own register
// back pressure stalls only the stages that hold data, empty stages still fill
// reset clears the stage valid bits only, payload registers keep their contents
// -----------------------------------------------------------------------------
module aabb_pair_merge_overlap #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   apmo_req_if.sink   req_bus,
   apmo_rsp_if.source rsp_bus
);

   localparam int C = COORD_WIDTH;

   apmo_pkg::pipe_ctrl_type pipe;

   logic signed [C:0]   center_x, center_y, center_z;
   logic        [C-1:0] half_x, half_y, half_z;
   logic        [C-1:0] overlap_x, overlap_y, overlap_z;
   logic                inside_x, inside_y, inside_z;
   logic                inside_all_ff;

   logic signed [C:0]   center_x_ff, center_y_ff, center_z_ff;
   logic        [C-1:0] half_x_ff, half_y_ff, half_z_ff;
   logic                contained_ff;

   apmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .pipe      (pipe)
   );

   apmo_axis #(.COORD_WIDTH(C)) u_axis_x (
      .clock         (clock),
      .pipe          (pipe),
      .center_a      (req_bus.first_center_x),
      .half_a        (req_bus.first_half_x),
      .center_b      (req_bus.second_center_x),
      .half_b        (req_bus.second_half_x),
      .merged_center (center_x),
      .merged_half   (half_x),
      .overlap       (overlap_x),
      .contained     (inside_x)
   );

   apmo_axis #(.COORD_WIDTH(C)) u_axis_y (
      .clock         (clock),
      .pipe          (pipe),
      .center_a      (req_bus.first_center_y),
      .half_a        (req_bus.first_half_y),
      .center_b      (req_bus.second_center_y),
      .half_b        (req_bus.second_half_y),
      .merged_center (center_y),
      .merged_half   (half_y),
      .overlap       (overlap_y),
      .contained     (inside_y)
   );

   apmo_axis #(.COORD_WIDTH(C)) u_axis_z (
      .clock         (clock),
      .pipe          (pipe),
      .center_a      (req_bus.first_center_z),
      .half_a        (req_bus.first_half_z),
      .center_b      (req_bus.second_center_z),
      .half_b        (req_bus.second_half_z),
      .merged_center (center_z),
      .merged_half   (half_z),
      .overlap       (overlap_z),
      .contained     (inside_z)
   );

   apmo_volume #(.COORD_WIDTH(C)) u_volume (
      .clock     (clock),
      .pipe      (pipe),
      .overlap_x (overlap_x),
      .overlap_y (overlap_y),
      .overlap_z (overlap_z),
      .volume    (rsp_bus.overlap_volume)
   );

   // containment and merged box delayed to line up with the volume
   always_ff @(posedge clock) begin
      if (pipe.load[apmo_pkg::STAGE_MERGE]) begin
         inside_all_ff <= inside_x && inside_y && inside_z;
      end
      if (pipe.load[apmo_pkg::STAGE_OUTPUT]) begin
         center_x_ff  <= center_x;
         center_y_ff  <= center_y;
         center_z_ff  <= center_z;
         half_x_ff    <= half_x;
         half_y_ff    <= half_y;
         half_z_ff    <= half_z;
         contained_ff <= inside_all_ff;
      end
   end

   assign rsp_bus.merged_center_x = center_x_ff;
   assign rsp_bus.merged_center_y = center_y_ff;
   assign rsp_bus.merged_center_z = center_z_ff;
   assign rsp_bus.merged_half_x   = half_x_ff;
   assign rsp_bus.merged_half_y   = half_y_ff;
   assign rsp_bus.merged_half_z   = half_z_ff;
   assign rsp_bus.contained       = contained_ff;

endmodule

/* hdl/apmo_checker.sv */
// -----------------------------------------------------------------------------
// apmo_checker
// port-level checks of the box pair merge block, bound to the top level
// -----------------------------------------------------------------------------
`include "aabb_pair_merge_overlap_macros.svh"

module apmo_checker #(
   parameter int COORD_WIDTH = apmo_pkg::COORD_WIDTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [3*COORD_WIDTH-1:0] rsp_volume,
   input logic                     rsp_contained
);

   logic       req_take, rsp_take;
   logic [2:0] inflight_ff, inflight_in;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // transactions accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (!req_take && rsp_take) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `APMO_ASSERT_RESET(a_reset_empty, reset, !rsp_valid)
   `APMO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_volume) && $stable(rsp_contained))
   `APMO_ASSERT_NOW(a_no_phantom, rsp_valid, inflight_ff != 3'd0 && inflight_ff <= 3'd4)
   `APMO_ASSERT_NEXT(a_latency, req_take ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

endmodule

bind aabb_pair_merge_overlap apmo_checker #(.COORD_WIDTH(COORD_WIDTH)) u_apmo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_volume    (rsp_bus.overlap_volume),
   .rsp_contained (rsp_bus.contained)
);

/* dv/tb_aabb_pair_merge_overlap.sv */
// -----------------------------------------------------------------------------
// tb_aabb_pair_merge_overlap
// self-checking bench for the box pair merge, overlap volume and containment
// block: directed corner pairs, then a random stream of near, nested and
// unrelated box pairs, with bursty input, a stalling output and a long
// output hold-off, every result compared field by field with a predictor
// -----------------------------------------------------------------------------
module tb_aabb_pair_merge_overlap;

   localparam int CW = apmo_pkg::COORD_WIDTH_DEFAULT;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PAIRS = 1000;

   // x is index 0, y index 1, z index 2
   typedef struct packed {
      logic [2:0][CW-1:0] center1;
      logic [2:0][CW-2:0] half1;
      logic [2:0][CW-1:0] center2;
      logic [2:0][CW-2:0] half2;
   } box_pair_type;

   typedef struct packed {
      logic [2:0][CW:0]   center;
      logic [2:0][CW-1:0] half;
      logic [3*CW-1:0]    volume;
      logic               contained;
   } box_merge_type;

   logic clock = 1'b0;
   logic reset;

   apmo_req_if #(.COORD_WIDTH(CW)) req_bus ();
   apmo_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

   aabb_pair_merge_overlap #(.COORD_WIDTH(CW)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   box_merge_type expected_merges [$];
   string axis_tag [3] = '{"x", "y", "z"};

   int error_count = 0;
   int pairs_accepted = 0;
   int contained_seen = 0;
   int overlap_seen = 0;
   int input_stall_cycles = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int hold_off_left = 0;
   int stretch_left = 0;
   int stall_mode = 0;

   task automatic report_mismatch(input string text);
      $display("ERROR @%0t: %s", $time, text);
      error_count++;
   endtask

   // expected merge result of one box pair
   function automatic box_merge_type merge_boxes(input box_pair_type p);
      box_merge_type r;
      int c1, h1, c2, h2, lo, hi, spread, ov;
      longint unsigned vol;
      bit nested;
      vol = 1;
      nested = 1'b1;
      for (int a = 0; a < 3; a++) begin
         c1 = int'($signed(p.center1[a]));
         h1 = int'(p.half1[a]);
         c2 = int'($signed(p.center2[a]));
         h2 = int'(p.half2[a]);
         lo = (c1 - h1 < c2 - h2) ? c1 - h1 : c2 - h2;
         hi = (c1 + h1 > c2 + h2) ? c1 + h1 : c2 + h2;
         r.center[a] = (CW+1)'((lo + hi) >>> 1);
         r.half[a] = CW'((hi - lo) >>> 1);
         spread = (c1 >= c2) ? c1 - c2 : c2 - c1;
         ov = h1 + h2 - spread;
         if (ov < 0) ov = 0;
         vol = vol * longint'(ov);
         if (spread + h2 > h1) nested = 1'b0;
      end
      r.volume = vol[3*CW-1:0];
      r.contained = nested;
      return r;
   endfunction

   task automatic check_merge(input box_merge_type got, input box_merge_type want);
      for (int a = 0; a < 3; a++) begin
         if (got.center[a] !== want.center[a])
            report_mismatch($sformatf("merged_center_%s got %0d expected %0d", axis_tag[a],
                                      $signed(got.center[a]), $signed(want.center[a])));
         if (got.half[a] !== want.half[a])
            report_mismatch($sformatf("merged_half_%s got %0d expected %0d", axis_tag[a],
                                      got.half[a], want.half[a]));
      end
      if (got.volume !== want.volume)
         report_mismatch($sformatf("overlap_volume got %0d expected %0d",
                                   got.volume, want.volume));
      if (got.contained !== want.contained)
         report_mismatch($sformatf("contained got %b expected %b",
                                   got.contained, want.contained));
   endtask

   // input and output monitor, predicts on each accepted pair
   always @(posedge clock) begin
      box_pair_type seen;
      box_merge_type got, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.center1 = {req_bus.first_center_z, req_bus.first_center_y,
                            req_bus.first_center_x};
            seen.half1 = {req_bus.first_half_z, req_bus.first_half_y, req_bus.first_half_x};
            seen.center2 = {req_bus.second_center_z, req_bus.second_center_y,
                            req_bus.second_center_x};
            seen.half2 = {req_bus.second_half_z, req_bus.second_half_y,
                          req_bus.second_half_x};
            want = merge_boxes(seen);
            expected_merges.push_back(want);
            pairs_accepted++;
            if (want.contained) contained_seen++;
            if (want.volume != 0) overlap_seen++;
         end
         if (req_bus.valid && !req_bus.ready) input_stall_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.center = {rsp_bus.merged_center_z, rsp_bus.merged_center_y,
                          rsp_bus.merged_center_x};
            got.half = {rsp_bus.merged_half_z, rsp_bus.merged_half_y, rsp_bus.merged_half_x};
            got.volume = rsp_bus.overlap_volume;
            got.contained = rsp_bus.contained;
            if (expected_merges.size() == 0) begin
               report_mismatch("result transaction with no pending box pair");
            end else begin
               want = expected_merges.pop_front();
               check_merge(got, want);
            end
         end
      end
   end

   // output stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left--;
      end else begin
         if (stretch_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(5, 60);
         end
         stretch_left--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pair(input box_pair_type p);
      req_bus.valid <= 1'b1;
      req_bus.first_center_x <= p.center1[0];
      req_bus.first_center_y <= p.center1[1];
      req_bus.first_center_z <= p.center1[2];
      req_bus.first_half_x <= p.half1[0];
      req_bus.first_half_y <= p.half1[1];
      req_bus.first_half_z <= p.half1[2];
      req_bus.second_center_x <= p.center2[0];
      req_bus.second_center_y <= p.center2[1];
      req_bus.second_center_z <= p.center2[2];
      req_bus.second_half_x <= p.half2[0];
      req_bus.second_half_y <= p.half2[1];
      req_bus.second_half_z <= p.half2[2];
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // random bursts with random gaps in between
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // stop offering and wait for every pending result
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_merges.size() != 0);
      @(posedge clock);
   endtask

   // same box pair on all three axes
   function automatic box_pair_type uniform_pair(input int c1, input int h1,
                                                 input int c2, input int h2);
      box_pair_type p;
      for (int a = 0; a < 3; a++) begin
         p.center1[a] = CW'(c1);
         p.half1[a] = (CW-1)'(h1);
         p.center2[a] = CW'(c2);
         p.half2[a] = (CW-1)'(h2);
      end
      return p;
   endfunction

   function automatic int pick_extreme(input bit is_center);
      case ($urandom_range(0, 5))
         0: return is_center ? -32768 : 0;
         1: return is_center ? 32767 : 32767;
         2: return 0;
         3: return 1;
         4: return is_center ? -1 : 32766;
         default: return is_center ? $urandom_range(0, 65535) : $urandom_range(0, 32767);
      endcase
   endfunction

   function automatic box_pair_type random_pair();
      box_pair_type p;
      int kind, c1, h1, h2, span, d;
      kind = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (kind <= 2) begin
            p.center1[a] = CW'($urandom_range(0, 65535));
            p.half1[a] = (CW-1)'($urandom_range(0, 32767));
            p.center2[a] = CW'($urandom_range(0, 65535));
            p.half2[a] = (CW-1)'($urandom_range(0, 32767));
         end else if (kind <= 6) begin
            // nearby boxes, overlapping or just apart
            c1 = $urandom_range(0, 65535) - 32768;
            h1 = $urandom_range(0, 4095);
            h2 = $urandom_range(0, 4095);
            span = h1 + h2 + 1;
            p.center1[a] = CW'(c1);
            p.half1[a] = (CW-1)'(h1);
            p.center2[a] = CW'(c1 + $urandom_range(0, 2 * span) - span);
            p.half2[a] = (CW-1)'(h2);
         end else if (kind <= 8) begin
            // second box nested in the first
            h1 = $urandom_range(0, 32767);
            h2 = $urandom_range(0, h1);
            d = $urandom_range(0, h1 - h2);
            c1 = $urandom_range(0, 32767) - 16384;
            p.center1[a] = CW'(c1);
            p.half1[a] = (CW-1)'(h1);
            p.center2[a] = $urandom_range(0, 1) ? CW'(c1 + d) : CW'(c1 - d);
            p.half2[a] = (CW-1)'(h2);
         end else begin
            p.center1[a] = CW'(pick_extreme(1'b1));
            p.half1[a] = (CW-1)'(pick_extreme(1'b0));
            p.center2[a] = CW'(pick_extreme(1'b1));
            p.half2[a] = (CW-1)'(pick_extreme(1'b0));
         end
      end
      return p;
   endfunction

   task automatic test_field_extremes();
      box_pair_type p;
      send_pair(uniform_pair(0, 0, 0, 0));
      send_pair(uniform_pair(32767, 32767, 32767, 32767));
      send_pair(uniform_pair(-32768, 32767, -32768, 32767));
      send_pair(uniform_pair(-32768, 32767, 32767, 32767));
      send_pair(uniform_pair(32767, 0, -32768, 0));
      send_pair(uniform_pair(-32768, 0, 32767, 32767));
      p = uniform_pair(0, 32767, 0, 32767);
      p.center1[0] = CW'(-32768);
      p.center1[2] = CW'(32767);
      p.center2[1] = CW'(-32768);
      p.half2[2] = '0;
      send_pair(p);
      wait_for_results();
   endtask

   task automatic test_touching_separated();
      box_pair_type p;
      send_pair(uniform_pair(0, 256, 512, 256));
      p = uniform_pair(0, 256, 0, 256);
      p.center2[0] = CW'(512);
      send_pair(p);
      p = uniform_pair(0, 256, 0, 256);
      p.center2[2] = CW'(20000);
      send_pair(p);
      send_pair(uniform_pair(0, 256, 511, 256));
      // odd sums that floor toward minus infinity
      send_pair(uniform_pair(-1, 0, -2, 0));
      send_pair(uniform_pair(-3, 2, 0, 0));
      wait_for_results();
   endtask

   task automatic test_containment();
      box_pair_type p;
      send_pair(uniform_pair(100, 500, 100, 500));
      send_pair(uniform_pair(0, 1000, 600, 400));
      send_pair(uniform_pair(0, 1000, 601, 400));
      send_pair(uniform_pair(0, 400, 0, 1000));
      p = uniform_pair(0, 1000, 0, 10);
      p.center2[1] = CW'(5000);
      send_pair(p);
      send_pair(uniform_pair(0, 100, 100, 0));
      send_pair(uniform_pair(-200, 300, -500, 0));
      wait_for_results();
   endtask

   task automatic test_random_stream();
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         pace_sender();
         send_pair(random_pair());
         if (i % 250 == 249) wait_for_results();
      end
      wait_for_results();
   endtask

   task automatic test_output_hold_off();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      hold_off_left = HOLD_OFF_CYCLES;
      @(posedge clock);
      for (int i = 0; i < 48; i++) send_pair(random_pair());
      wait_for_results();
   endtask

   task automatic test_pause_mid_stream();
      for (int i = 0; i < 20; i++) send_pair(random_pair());
      wait_for_results();
      for (int i = 0; i < 20; i++) begin
         pace_sender();
         send_pair(random_pair());
      end
      wait_for_results();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.first_center_x = '0;
      req_bus.first_center_y = '0;
      req_bus.first_center_z = '0;
      req_bus.first_half_x = '0;
      req_bus.first_half_y = '0;
      req_bus.first_half_z = '0;
      req_bus.second_center_x = '0;
      req_bus.second_center_y = '0;
      req_bus.second_center_z = '0;
      req_bus.second_half_x = '0;
      req_bus.second_half_y = '0;
      req_bus.second_half_z = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_touching_separated();
      test_containment();
      test_random_stream();
      test_output_hold_off();
      test_pause_mid_stream();

      wait_for_results();
      repeat (2 * apmo_pkg::STAGES + 4) @(posedge clock);

      $display("covered %0d box pairs, %0d nested, %0d with nonzero overlap",
               pairs_accepted, contained_seen, overlap_seen);
      $display("input held off for %0d cycles by output back pressure", input_stall_cycles);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/apmo_pkg.sv
hdl/apmo_if.sv
hdl/apmo_ctrl.sv
hdl/apmo_axis.sv
hdl/apmo_volume.sv
hdl/aabb_pair_merge_overlap.sv
hdl/apmo_checker.sv
dv/tb_aabb_pair_merge_overlap.sv
